// File: design/gre_pkg.sv
// shared types, constants and codes of the graph node rewire engine
package gre_pkg;

    // graph size and field widths
    localparam int NODE_COUNT = 32;
    localparam int NODE_W     = 5;
    localparam int ROW_W      = 32;
    localparam int PROB_W     = 17;
    localparam int DRAW_W     = 16;
    localparam int KIND_W     = 2;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register index taken from the word address bit
    localparam logic REG_PROB = 1'b0;

    // request types
    localparam logic REQ_REWIRE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EQUAL   = 2'd3;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [ROW_W-1:0]  row_t;

    // bits of a row that name existing nodes
    localparam row_t NODE_MASK = {ROW_W{1'b1}} >> (ROW_W - NODE_COUNT);

    // access request from the sequencer to the adjacency memory
    typedef struct packed {
        logic  rd_en;
        node_t rd_addr;
        logic  wr_en;
        node_t wr_addr;
        row_t  wr_data;
    } mem_req_t;

endpackage

// File: design/graph_node_rewire_engine.sv
// Graph node rewire engine: keeps a 32-node undirected graph as an adjacency bit
// matrix in a one-port-read, one-port-write row memory that is empty after reset
// (per-row valid flags, no clearing pass). A request is taken when start is high
// and busy is low; each result is shown for one cycle with result_valid and
// cannot be held off. Timing is set by the row memory, which does one
// read-modify-write of a neighbor row per cycle. Requests with equal or
// invalid nodes, loads, empty rewire events and plain rewires of a node
// without edges need no neighbor walk; a rewire walks the rows of the
// removed neighbors of i and then the rows of the copied neighbors of j
// (neither set can hold more than 30 rows when rewiring).
module graph_node_rewire_engine
    import gre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic              req_type,
    input  node_t             node_i,
    input  node_t             node_j,
    input  logic [DRAW_W-1:0] random_draw,
    output logic              result_valid,
    output logic [KIND_W-1:0] kind,
    output node_t             node_low,
    output node_t             node_high,
    output logic              last
);

    logic [PROB_W-1:0] prob_reg;
    logic              cfg_write;
    mem_req_t          mem_req;
    row_t              rd_data;

    // configuration register write
    assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_PROB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prob_reg <= '0;
        end
        else if (cfg_write)
        begin
            prob_reg <= pwdata[PROB_W-1:0];
        end
    end

    // register readback
    assign prdata = (paddr[ADDR_W-1] == REG_PROB) ? DATA_W'(prob_reg) : '0;
    assign pready = 1'b1;

    // request sequencer
    gre_seq u_seq
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .req_type           (req_type),
        .node_i             (node_i),
        .node_j             (node_j),
        .random_draw        (random_draw),
        .rewire_probability (prob_reg),
        .busy               (busy),
        .mem_req            (mem_req),
        .rd_data            (rd_data),
        .result_valid       (result_valid),
        .kind               (kind),
        .node_low           (node_low),
        .node_high          (node_high),
        .last               (last)
    );

    // adjacency rows
    gre_row_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

// File: design/gre_row_mem.sv
// adjacency row memory with per-row valid flags and write-to-read forwarding
module gre_row_mem
    import gre_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output row_t     rd_data
);

    row_t                  mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] row_valid_reg;
    row_t                  rd_data_reg;

    // row storage, one write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // valid flags, cleared at reset so the graph starts empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            row_valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // registered read, a same-cycle write to the same row is forwarded
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            if (req.wr_en && (req.wr_addr == req.rd_addr))
            begin
                rd_data_reg <= req.wr_data;
            end
            else if (row_valid_reg[req.rd_addr])
            begin
                rd_data_reg <= mem[req.rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/gre_seq.sv
// request sequencer: walks neighbor rows with one read-modify-write per cycle
module gre_seq
    import gre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              req_type,
    input  node_t             node_i,
    input  node_t             node_j,
    input  logic [DRAW_W-1:0] random_draw,
    input  logic [PROB_W-1:0] rewire_probability,
    output logic              busy,
    output mem_req_t          mem_req,
    input  row_t              rd_data,
    output logic              result_valid,
    output logic [KIND_W-1:0] kind,
    output node_t             node_low,
    output node_t             node_high,
    output logic              last
);

    // state codes
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOAD_I  = 4'd1;
    localparam logic [3:0] S_LOAD_J  = 4'd2;
    localparam logic [3:0] S_CHECK   = 4'd3;
    localparam logic [3:0] S_GETJ    = 4'd4;
    localparam logic [3:0] S_REMOVE  = 4'd5;
    localparam logic [3:0] S_ADD     = 4'd6;
    localparam logic [3:0] S_JOIN_J  = 4'd7;
    localparam logic [3:0] S_WRITE_I = 4'd8;

    // lowest set bit of a row
    function automatic node_t lowest_bit(input row_t v);
        node_t idx;
        idx = '0;
        for (int k = ROW_W - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                idx = node_t'(k);
            end
        end
        return idx;
    endfunction

    logic [3:0]        state_reg, state_next;
    node_t             node_i_reg, node_i_next;
    node_t             node_j_reg, node_j_next;
    logic              rewiring_reg, rewiring_next;
    row_t              scan_reg, scan_next;
    row_t              copy_reg, copy_next;
    row_t              rowj_reg, rowj_next;
    row_t              acc_reg, acc_next;
    logic              pend_reg, pend_next;
    node_t             pend_addr_reg, pend_addr_next;

    logic              result_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    node_t             node_low_reg, node_high_reg;
    logic              last_reg;

    logic              emit_en;
    logic [KIND_W-1:0] emit_kind;
    node_t             emit_a, emit_b;
    logic              emit_last;

    row_t              bit_i, bit_j;
    node_t             scan_low;
    logic              out_of_range;

    assign bit_i        = row_t'(1) << node_i_reg;
    assign bit_j        = row_t'(1) << node_j_reg;
    assign scan_low     = lowest_bit(scan_reg);
    assign out_of_range = ({1'b0, node_i} >= (NODE_W + 1)'(NODE_COUNT))
                       || ({1'b0, node_j} >= (NODE_W + 1)'(NODE_COUNT));

    // next state and memory requests
    always_comb
    begin
        state_next     = state_reg;
        node_i_next    = node_i_reg;
        node_j_next    = node_j_reg;
        rewiring_next  = rewiring_reg;
        scan_next      = scan_reg;
        copy_next      = copy_reg;
        rowj_next      = rowj_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        mem_req        = '0;
        emit_en        = 1'b0;
        emit_kind      = KIND_NONE;
        emit_a         = '0;
        emit_b         = '0;
        emit_last      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    node_i_next   = node_i;
                    node_j_next   = node_j;
                    rewiring_next = {1'b0, random_draw} < rewire_probability;
                    if (out_of_range)
                    begin
                        emit_en   = 1'b1;
                        emit_last = 1'b1;
                    end
                    else if (node_i == node_j)
                    begin
                        emit_en   = 1'b1;
                        emit_kind = KIND_EQUAL;
                        emit_a    = node_i;
                        emit_b    = node_i;
                        emit_last = 1'b1;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = node_i;
                        state_next      = (req_type == REQ_LOAD) ? S_LOAD_I : S_CHECK;
                    end
                end
            end

            // load: set bit j in row i, fetch row j
            S_LOAD_I:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = node_i_reg;
                mem_req.wr_data = rd_data | bit_j;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = node_j_reg;
                state_next      = S_LOAD_J;
            end

            // load: set bit i in row j and report the edge
            S_LOAD_J:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = node_j_reg;
                mem_req.wr_data = rd_data | bit_i;
                emit_en         = 1'b1;
                emit_kind       = KIND_ADDED;
                emit_a          = node_i_reg;
                emit_b          = node_j_reg;
                emit_last       = 1'b1;
                state_next      = S_IDLE;
            end

            // rewire: row i is here, decide empty event or walk
            S_CHECK:
            begin
                if ((rewiring_reg && rd_data[node_j_reg])
                    || (!rewiring_reg && ((rd_data & NODE_MASK) == '0)))
                begin
                    emit_en    = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next       = rd_data & NODE_MASK;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = node_j_reg;
                    state_next      = S_GETJ;
                end
            end

            // capture row j for the copy phase
            S_GETJ:
            begin
                rowj_next  = rd_data;
                copy_next  = rd_data & NODE_MASK & ~bit_i;
                acc_next   = '0;
                pend_next  = 1'b0;
                state_next = S_REMOVE;
            end

            // remove edges of i: read neighbor row, clear bit i next cycle
            S_REMOVE:
            begin
                if (pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pend_addr_reg;
                    mem_req.wr_data = rd_data & ~bit_i;
                    emit_en         = 1'b1;
                    emit_kind       = KIND_REMOVED;
                    emit_a          = node_i_reg;
                    emit_b          = pend_addr_reg;
                    emit_last       = !rewiring_reg && (scan_reg == '0);
                end
                if (scan_reg != '0)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_low;
                    scan_next       = scan_reg & ~(row_t'(1) << scan_low);
                    pend_next       = 1'b1;
                    pend_addr_next  = scan_low;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (rewiring_reg)
                        begin
                            scan_next  = copy_reg;
                            state_next = S_ADD;
                        end
                        else
                        begin
                            state_next = S_WRITE_I;
                        end
                    end
                end
            end

            // copy neighbors of j: read neighbor row, set bit i next cycle
            S_ADD:
            begin
                if (pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pend_addr_reg;
                    mem_req.wr_data = rd_data | bit_i;
                    acc_next        = acc_reg | (row_t'(1) << pend_addr_reg);
                    emit_en         = 1'b1;
                    emit_kind       = KIND_ADDED;
                    emit_a          = node_i_reg;
                    emit_b          = pend_addr_reg;
                end
                if (scan_reg != '0)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_low;
                    scan_next       = scan_reg & ~(row_t'(1) << scan_low);
                    pend_next       = 1'b1;
                    pend_addr_next  = scan_low;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_JOIN_J;
                    end
                end
            end

            // join i to j last
            S_JOIN_J:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = node_j_reg;
                mem_req.wr_data = rowj_reg | bit_i;
                acc_next        = acc_reg | bit_j;
                emit_en         = 1'b1;
                emit_kind       = KIND_ADDED;
                emit_a          = node_i_reg;
                emit_b          = node_j_reg;
                emit_last       = 1'b1;
                state_next      = S_WRITE_I;
            end

            // write the new row of i
            S_WRITE_I:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = node_i_reg;
                mem_req.wr_data = acc_reg;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pend_reg         <= pend_next;
            result_valid_reg <= emit_en;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        node_i_reg    <= node_i_next;
        node_j_reg    <= node_j_next;
        rewiring_reg  <= rewiring_next;
        scan_reg      <= scan_next;
        copy_reg      <= copy_next;
        rowj_reg      <= rowj_next;
        acc_reg       <= acc_next;
        pend_addr_reg <= pend_addr_next;
    end

    // result register, edge reported as a sorted pair
    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            kind_reg      <= emit_kind;
            node_low_reg  <= (emit_a < emit_b) ? emit_a : emit_b;
            node_high_reg <= (emit_a < emit_b) ? emit_b : emit_a;
            last_reg      <= emit_last;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign node_low     = node_low_reg;
    assign node_high    = node_high_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    // neighbor walks never touch the row of i itself
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_REMOVE) || (state_reg == S_ADD)) && mem_req.wr_en
        |-> (mem_req.wr_addr != node_i_reg))
    else $error("neighbor walk wrote row of node i");

    // a pending row read exists only inside a neighbor walk
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ((state_reg == S_REMOVE) || (state_reg == S_ADD)))
    else $error("pending read outside neighbor walk");

    // reported edges are strictly ordered pairs
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && ((kind_reg == KIND_ADDED) || (kind_reg == KIND_REMOVED))
        |-> (node_low_reg < node_high_reg))
    else $error("edge reported with unordered ends");

    // the copy walk never visits node i or node j
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |-> (!scan_reg[node_i_reg] && !scan_reg[node_j_reg]))
    else $error("copy walk includes an end node");
`endif

endmodule
